// File: sv/nsv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// nsv_pkg
// Shared types, codes and character constants of the NMEA sentence validator.
// -----------------------------------------------------------------------------
package nsv_pkg;

  localparam logic [7:0] ChDollar = 8'h24;  // '$'
  localparam logic [7:0] ChComma  = 8'h2C;  // ','
  localparam logic [7:0] ChStar   = 8'h2A;  // '*'
  localparam logic [7:0] ChOne    = 8'h31;  // '1'
  localparam logic [7:0] ChA      = 8'h41;  // 'A'
  localparam logic [7:0] ChZero   = 8'h30;  // '0'

  localparam logic [47:0] GgaText = "$GPGGA";
  localparam logic [47:0] RmcText = "$GPRMC";

  // Header length, fix field positions, saturation limits
  localparam logic [2:0] HdrLen    = 3'd6;
  localparam logic [2:0] GgaFixFld = 3'd6;
  localparam logic [2:0] RmcFixFld = 3'd2;
  localparam logic [2:0] CntMax    = 3'd7;
  localparam logic [1:0] StarMax   = 2'd3;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_GGA     = 2'd1,
    KIND_RMC     = 2'd2
  } nsv_kind_e;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_HEADER   = 3'd1,
    ERR_NO_FIX   = 3'd2,
    ERR_NO_STAR  = 3'd3,
    ERR_CHECKSUM = 3'd4
  } nsv_err_e;

  typedef struct packed {
    logic      ok;
    nsv_kind_e kind;
    nsv_err_e  err;
  } nsv_result_t;

  // Byte idx of a six-character header string, first character at the top
  function automatic logic [7:0] text_byte(input logic [47:0] txt, input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = txt[47:40];
      3'd1:    ch = txt[39:32];
      3'd2:    ch = txt[31:24];
      3'd3:    ch = txt[23:16];
      3'd4:    ch = txt[15:8];
      3'd5:    ch = txt[7:0];
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Uppercase hex digit for a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) ch = ChZero + {4'd0, nib};
    else             ch = ChA + {4'd0, nib} - 8'd10;
    return ch;
  endfunction

endpackage
`default_nettype wire

// File: sv/nsv_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// nsv_in_if / nsv_out_if
// Valid/ready channels: sentence bytes in, validation results out.
// -----------------------------------------------------------------------------
interface nsv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface nsv_out_if;
  logic       valid;
  logic       ready;
  logic       sentence_ok;
  logic [1:0] sentence_kind;
  logic [2:0] error_code;

  modport source (output valid, sentence_ok, sentence_kind, error_code, input ready);
  modport sink   (input valid, sentence_ok, sentence_kind, error_code, output ready);
endinterface
`default_nettype wire

// File: sv/nsv_sentence_core.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// nsv_sentence_core
// Per-sentence parse state and the single-beat update: field split, header
// and fix checks, checksum XOR and hex compare, final verdict.
// -----------------------------------------------------------------------------
module nsv_sentence_core
  import nsv_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        beat_i,   // process one byte this cycle
  input  wire logic [7:0]  byte_i,
  input  wire logic        last_i,
  output nsv_result_t      result_o  // valid with a last byte
);

  logic       start_q, start_d;
  logic [2:0] fld_q, fld_d;
  logic [2:0] chr_q, chr_d;
  logic       gga_q, gga_d;
  logic       rmc_q, rmc_d;
  logic       fix_q, fix_d;
  logic [7:0] xacc_q, xacc_d;
  logic       star_q, star_d;
  logic [1:0] nstar_q, nstar_d;
  logic [1:0] hexm_q, hexm_d;
  logic       gga_f, rmc_f;

  always_comb begin
    // Sentence start: restart from a clean slate
    fld_d   = start_q ? 3'd0 : fld_q;
    chr_d   = start_q ? 3'd0 : chr_q;
    gga_d   = start_q ? 1'b1 : gga_q;
    rmc_d   = start_q ? 1'b1 : rmc_q;
    fix_d   = start_q ? 1'b0 : fix_q;
    xacc_d  = start_q ? 8'd0 : xacc_q;
    star_d  = start_q ? 1'b0 : star_q;
    nstar_d = start_q ? 2'd0 : nstar_q;
    hexm_d  = start_q ? 2'd0 : hexm_q;

    if (byte_i == ChComma) begin
      if (fld_d == 3'd0 && chr_d != HdrLen) begin
        gga_d = 1'b0;
        rmc_d = 1'b0;
      end
      if (fld_d != CntMax) fld_d = fld_d + 3'd1;
      chr_d = 3'd0;
    end else begin
      if (fld_d == 3'd0 && chr_d < HdrLen) begin
        if (byte_i != text_byte(GgaText, chr_d)) gga_d = 1'b0;
        if (byte_i != text_byte(RmcText, chr_d)) rmc_d = 1'b0;
      end
      if (gga_d && fld_d == GgaFixFld)
        fix_d = (chr_d == 3'd0) && (byte_i == ChOne);
      if (rmc_d && fld_d == RmcFixFld && chr_d == 3'd0)
        fix_d = (byte_i == ChA);
      if (chr_d != CntMax) chr_d = chr_d + 3'd1;
    end

    // Checksum: the leading byte never enters the XOR
    if (!start_q) begin
      if (!star_d) begin
        if (byte_i == ChStar) star_d = 1'b1;
        else                  xacc_d = xacc_d ^ byte_i;
      end else begin
        if (nstar_d == 2'd0 && byte_i == hex_char(xacc_d[7:4])) hexm_d[0] = 1'b1;
        if (nstar_d == 2'd1 && byte_i == hex_char(xacc_d[3:0])) hexm_d[1] = 1'b1;
        if (nstar_d != StarMax) nstar_d = nstar_d + 2'd1;
      end
    end

    start_d = last_i;

    // Header still open at the end counts only if exactly six characters
    gga_f = gga_d;
    rmc_f = rmc_d;
    if (fld_d == 3'd0 && chr_d != HdrLen) begin
      gga_f = 1'b0;
      rmc_f = 1'b0;
    end

    if (gga_f)      result_o.kind = KIND_GGA;
    else if (rmc_f) result_o.kind = KIND_RMC;
    else            result_o.kind = KIND_UNKNOWN;

    if (!gga_f && !rmc_f)   result_o.err = ERR_HEADER;
    else if (!fix_d)        result_o.err = ERR_NO_FIX;
    else if (!star_d)       result_o.err = ERR_NO_STAR;
    else if (hexm_d != 2'b11) result_o.err = ERR_CHECKSUM;
    else                    result_o.err = ERR_OK;

    result_o.ok = (result_o.err == ERR_OK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
      fld_q   <= 3'd0;
      chr_q   <= 3'd0;
      gga_q   <= 1'b0;
      rmc_q   <= 1'b0;
      fix_q   <= 1'b0;
      xacc_q  <= 8'd0;
      star_q  <= 1'b0;
      nstar_q <= 2'd0;
      hexm_q  <= 2'd0;
    end else if (beat_i) begin
      start_q <= start_d;
      fld_q   <= fld_d;
      chr_q   <= chr_d;
      gga_q   <= gga_d;
      rmc_q   <= rmc_d;
      fix_q   <= fix_d;
      xacc_q  <= xacc_d;
      star_q  <= star_d;
      nstar_q <= nstar_d;
      hexm_q  <= hexm_d;
    end
  end

endmodule
`default_nettype wire

// File: sv/nmea_sentence_validator.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// nmea_sentence_validator
// Checks NMEA GGA/RMC sentences byte by byte: header, fix status, checksum.
// -----------------------------------------------------------------------------
// Usage:
//   in_i  : one sentence byte per beat; last_byte marks the final byte. The
//           byte after a final byte (or the first after reset) opens a new
//           sentence.
//   out_o : one result beat per sentence (sentence_ok, sentence_kind,
//           error_code); bytes that are not final produce no beat.
// Structure: input register -> combinational parse/verdict logic -> result
//   register. Parse state lives in nsv_sentence_core.
// Throughput: one byte per cycle, except while a final byte waits for the
//   result register to free (see Stall).
// Result path: a final byte is held in the input register, then its result
//   is registered in the result register, which drives out_o.
// Stall: while a result waits on out_o, non-final bytes keep flowing; a
//   final byte waits in the input register, with in_i.ready low, until the
//   result register frees.
// Reset (async, active low): clears both registers' valid bits and returns
//   the parser to the start of a sentence.
// -----------------------------------------------------------------------------
module nmea_sentence_validator
  import nsv_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  nsv_in_if.sink     in_i,
  nsv_out_if.source  out_o
);

  // Input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // Result register
  logic        out_valid_q, out_valid_d;
  nsv_result_t out_res_q;
  nsv_result_t core_res;

  logic out_free;  // result register can take a new result this cycle
  logic fire;      // registered byte goes through the parser
  logic take;      // input beat accepted

  assign out_free = !out_valid_q || out_o.ready;
  // A final byte needs a free result slot; other bytes never wait
  assign fire     = s1_valid_q && (!s1_last_q || out_free);
  assign in_i.ready = !s1_valid_q || fire;
  assign take     = in_i.valid && in_i.ready;

  assign s1_valid_d  = take || (s1_valid_q && !fire);
  assign out_valid_d = (fire && s1_last_q) || (out_valid_q && !out_o.ready);

  nsv_sentence_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .beat_i   (fire),
    .byte_i   (s1_byte_q),
    .last_i   (s1_last_q),
    .result_o (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_byte_q <= in_i.data_byte;
      s1_last_q <= in_i.last_byte;
    end
    if (fire && s1_last_q) begin
      out_res_q <= core_res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.sentence_ok   = out_res_q.ok;
  assign out_o.sentence_kind = out_res_q.kind;
  assign out_o.error_code    = out_res_q.err;

endmodule
`default_nettype wire

// File: sv/nsv_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// nsv_checker
// Port-level checks on the validator's result channel.
// -----------------------------------------------------------------------------
module nsv_checker
  import nsv_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       ok_i,
  input wire logic [1:0] kind_i,
  input wire logic [2:0] err_i
);

  // Stalled result stays up
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(ok_i) && $stable(kind_i) && $stable(err_i))
    else $error("result payload changed while stalled");

  // ok flag agrees with the error code
  a_ok_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (ok_i == (err_i == ERR_OK)))
    else $error("sentence_ok disagrees with error_code");

  // Unknown kind exactly when the header failed
  a_kind_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((kind_i == KIND_UNKNOWN) == (err_i == ERR_HEADER)))
    else $error("sentence_kind disagrees with header error");

endmodule

bind nmea_sentence_validator nsv_checker u_nsv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .ok_i        (out_o.sentence_ok),
  .kind_i      (out_o.sentence_kind),
  .err_i       (out_o.error_code)
);
`default_nettype wire
